// File: design/fbra_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbra_pkg
// shared types and constants of the free block run allocator
// ----------------------------------------------------------------------------
package fbra_pkg;

  // size of the used/free bitmap
  localparam int MAX_BLOCKS = 32;
  localparam int IDX_W      = $clog2(MAX_BLOCKS);
  localparam int PTR_W      = $clog2(MAX_BLOCKS + 1);

  // field and register widths
  localparam int START_W    = 5;
  localparam int LENGTH_W   = 16;
  localparam int BINDEX_W   = 5;
  localparam int BCOUNT_W   = 6;
  localparam int BWORDS_W   = 11;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;
  localparam int CAP_W      = LENGTH_W + 1;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_WORDS = 2'd1;

  // register reset values
  localparam logic [BCOUNT_W-1:0] BCOUNT_RST = 6'd32;
  localparam logic [BWORDS_W-1:0] BWORDS_RST = 11'd4;

  // result status codes
  localparam logic STATUS_GRANT = 1'b0;
  localparam logic STATUS_FAIL  = 1'b1;

  typedef struct packed {
    logic [START_W-1:0]  start_block;
    logic [LENGTH_W-1:0] file_length;
  } in_word_t;

  typedef struct packed {
    logic [BINDEX_W-1:0] block_index;
    logic                status;
    logic                last;
  } out_word_t;

  // controller to datapath
  typedef struct packed {
    logic load_req;   // capture request, pointer to start, capacity cleared
    logic restart;    // pointer back to start, capacity cleared
    logic step;       // advance pointer
    logic add;        // add block_words to capacity
    logic grant;      // mark current block used and emit it
    logic emit_fail;  // emit the failure word
  } ctl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic bad_req;    // incoming request fails before any scan
    logic scan_end;   // pointer at or past the end of blocks in use
    logic blk_free;   // current block is free
    logic reach;      // capacity plus one block covers the length
    logic out_slot;   // output register can take a word this cycle
  } dp_stat_t;

endpackage

// File: design/fbra_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbra_dp
// bitmap, scan pointer, capacity accumulator, config and output register
// ----------------------------------------------------------------------------
module fbra_dp (
  input  logic                                clk,
  input  logic                                rst_n,
  input  fbra_pkg::ctl_cmd_t                  cmd,
  output fbra_pkg::dp_stat_t                  stat,
  input  fbra_pkg::in_word_t                  in_word,
  output logic                                out_valid,
  input  logic                                out_stall,
  output fbra_pkg::out_word_t                 out_word,
  input  logic                                cfg_we,
  input  logic [fbra_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [fbra_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
  import fbra_pkg::*;

  logic [BCOUNT_W-1:0]   bcount_r;
  logic [BWORDS_W-1:0]   bwords_r;
  logic [MAX_BLOCKS-1:0] used_r;
  logic [PTR_W-1:0]      ptr_r, ptr_nxt;
  logic [START_W-1:0]    start_r;
  logic [LENGTH_W-1:0]   length_r;
  logic [CAP_W-1:0]      cap_r, cap_nxt;
  logic [CAP_W-1:0]      cap_add;
  logic                  out_valid_r, out_valid_nxt;
  out_word_t             out_word_r, out_word_nxt;
  logic [PTR_W-1:0]      limit;
  logic [IDX_W-1:0]      cur_idx;

  // blocks in use, capped at the bitmap size
  assign limit = (bcount_r > BCOUNT_W'(MAX_BLOCKS)) ? PTR_W'(MAX_BLOCKS)
                                                     : PTR_W'(bcount_r);
  assign cur_idx = ptr_r[IDX_W-1:0];
  assign cap_add = cap_r + CAP_W'(bwords_r);

  assign stat.bad_req  = (in_word.file_length == '0) || (bwords_r == '0) ||
                         (PTR_W'(in_word.start_block) >= limit);
  assign stat.scan_end = (ptr_r >= limit);
  assign stat.blk_free = !used_r[cur_idx];
  assign stat.reach    = (cap_add >= CAP_W'(length_r));
  assign stat.out_slot = !out_valid_r || !out_stall;

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bcount_r <= BCOUNT_RST;
      bwords_r <= BWORDS_RST;
    end else if (cfg_we) begin
      if (cfg_index == CFG_BLOCK_COUNT) begin
        bcount_r <= cfg_wdata[BCOUNT_W-1:0];
      end else if (cfg_index == CFG_BLOCK_WORDS) begin
        bwords_r <= cfg_wdata[BWORDS_W-1:0];
      end
    end
  end

  // bitmap
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= '0;
    end else if (cmd.grant) begin
      used_r[cur_idx] <= 1'b1;
    end
  end

  // request capture
  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      start_r  <= in_word.start_block;
      length_r <= in_word.file_length;
    end
  end

  always_comb begin
    ptr_nxt = ptr_r;
    cap_nxt = cap_r;
    if (cmd.load_req) begin
      ptr_nxt = PTR_W'(in_word.start_block);
      cap_nxt = '0;
    end else if (cmd.restart) begin
      ptr_nxt = PTR_W'(start_r);
      cap_nxt = '0;
    end else begin
      if (cmd.step) ptr_nxt = ptr_r + PTR_W'(1);
      if (cmd.add)  cap_nxt = cap_add;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptr_r <= '0;
      cap_r <= '0;
    end else begin
      ptr_r <= ptr_nxt;
      cap_r <= cap_nxt;
    end
  end

  // output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_word_nxt  = out_word_r;
    if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;
    if (cmd.grant) begin
      out_valid_nxt            = 1'b1;
      out_word_nxt.block_index = BINDEX_W'(cur_idx);
      out_word_nxt.status      = STATUS_GRANT;
      out_word_nxt.last        = stat.reach;
    end else if (cmd.emit_fail) begin
      out_valid_nxt            = 1'b1;
      out_word_nxt.block_index = '0;
      out_word_nxt.status      = STATUS_FAIL;
      out_word_nxt.last        = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_word_r <= out_word_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  // a grant only hits a free block inside the range, with room at the output
  a_grant_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.grant |-> (stat.blk_free && !stat.scan_end && stat.out_slot))
    else $error("grant on used or out of range block");

  // the granted block reads as used afterwards
  a_grant_marks: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.grant |=> used_r[$past(cur_idx)])
    else $error("granted block not marked used");

  // never two words loaded at once
  a_one_emit: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.grant && cmd.emit_fail))
    else $error("grant and failure in the same cycle");

endmodule

// File: design/fbra_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbra_ctrl
// sequencer for the check pass and the grant pass
// ----------------------------------------------------------------------------
module fbra_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  fbra_pkg::dp_stat_t stat,
  output fbra_pkg::ctl_cmd_t cmd
);
  import fbra_pkg::*;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_CHECK = 2'd1;
  localparam logic [1:0] ST_GRANT = 2'd2;
  localparam logic [1:0] ST_FAIL  = 2'd3;

  logic [1:0] state_r, state_nxt;

  assign in_stall = (state_r != ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load_req = 1'b1;
          state_nxt    = stat.bad_req ? ST_FAIL : ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (stat.scan_end) begin
          state_nxt = ST_FAIL;
        end else if (stat.blk_free && stat.reach) begin
          cmd.restart = 1'b1;
          state_nxt   = ST_GRANT;
        end else begin
          cmd.step = 1'b1;
          cmd.add  = stat.blk_free;
        end
      end
      ST_GRANT: begin
        if (stat.scan_end) begin
          state_nxt = ST_IDLE;
        end else if (!stat.blk_free) begin
          cmd.step = 1'b1;
        end else if (stat.out_slot) begin
          cmd.grant = 1'b1;
          cmd.add   = 1'b1;
          cmd.step  = 1'b1;
          if (stat.reach) state_nxt = ST_IDLE;
        end
      end
      ST_FAIL: begin
        if (stat.out_slot) begin
          cmd.emit_fail = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// File: design/free_block_run_allocator_top.sv
`timescale 1ns / 1ps
// order after accept: the check pass sums free capacity from the start block, then the grant
// pass restarts there, passes used blocks and grants free ones until the length is covered
// requests are taken one at a time: in_stall stays high until the controller is idle again
// each pass walks one bitmap entry per cycle; a granted word needs a free output slot
// a request that is rejected up front goes straight to the failure word, with no scan
// reset (rst_n low, synchronous): all blocks free, block_count 32, block_words 4, no word pending
// ----------------------------------------------------------------------------
// free_block_run_allocator_top
// bitmap allocator: grants the free blocks from a start block that cover the length, searching up to the end
// ----------------------------------------------------------------------------
module free_block_run_allocator_top (
  input  logic                                clk,
  input  logic                                rst_n,
  // request channel
  input  logic                                in_valid,
  output logic                                in_stall,
  input  fbra_pkg::in_word_t                  in_word,
  // result channel
  output logic                                out_valid,
  input  logic                                out_stall,
  output fbra_pkg::out_word_t                 out_word,
  // register writes
  input  logic                                cfg_we,
  input  logic [fbra_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [fbra_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
  import fbra_pkg::*;

  ctl_cmd_t cmd;
  dp_stat_t stat;

  // controller: idle, check pass (sum free capacity), grant pass, failure word
  fbra_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  // datapath: bitmap, scan pointer, capacity sum, output register
  // capacity is compared against the length instead of dividing the length
  // by block_words, which gives the same block count rounded up
  fbra_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .stat      (stat),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

endmodule
